// File: hdl/sld_pkg.sv
// Shared types and constants for the sync/length deframer.
// No dependencies; the core, front end, queue and output stage refer to this package.
package sld_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Configuration register indexes and port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

    // Register reset values
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hBE;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'hEF;
    localparam logic [15:0] RST_MAX_LEN     = 16'd1024;

    // Hard ceiling on payload length
    localparam int DEFAULT_MAX_LEN_LIMIT = 65535;

    // Queue between classifier and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic       last_of_message;
    } t_result;

endpackage

// File: hdl/sld_in_if.sv
// Input byte channel: valid/ready handshake carrying one stream byte.
// Depends on nothing.
interface sld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// File: hdl/sld_out_if.sv
// Result channel: valid/ready handshake carrying one deframer result.
// Depends on nothing.
interface sld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       last_of_message;

    modport source (output valid, output result_kind, output payload_byte,
                    output last_of_message, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input last_of_message, output ready);
endinterface

// File: hdl/sync_length_deframer_core.sv
// Sync-word, length-prefixed deframer: takes one stream byte per clock, hunts
// for the two configured header bytes, gathers a 4-byte little-endian length
// and passes on the payload bytes, marking the last; a zero length gives an
// empty-message result and a length above the smaller of the CFG_MAX_LEN
// register and MAX_LEN_LIMIT gives an error result, after which the hunt
// restarts. A byte is taken every clock while the four-entry result queue
// has room; each result passes through the queue and the output register
// before it is presented on the result channel. Write configuration only
// while no results are pending.
// Depends on sld_pkg, sld_in_if, sld_out_if, sld_front, sld_queue, sld_back.
module sync_length_deframer_core #(
    parameter int MAX_LEN_LIMIT = sld_pkg::DEFAULT_MAX_LEN_LIMIT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sld_in_if.sink                         i_in,
    sld_out_if.source                      o_out
);

    logic             q_full;
    logic             push;
    sld_pkg::t_result push_item;
    logic             pop;
    logic             q_valid;
    sld_pkg::t_result q_item;
    sld_pkg::t_result out_item;

    sld_front #(
        .MAX_LEN_LIMIT (MAX_LEN_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .i_in_byte   (i_in.data_byte),
        .o_in_ready  (i_in.ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    sld_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    sld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (out_item)
    );

    assign o_out.result_kind     = out_item.result_kind;
    assign o_out.payload_byte    = out_item.payload_byte;
    assign o_out.last_of_message = out_item.last_of_message;

endmodule

// File: hdl/sld_front.sv
// Front end: configuration registers, header hunt, length gather and payload count.
// Depends on sld_pkg; pushes classified results into the queue.
module sld_front #(
    parameter int MAX_LEN_LIMIT = sld_pkg::DEFAULT_MAX_LEN_LIMIT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic [7:0]                     i_in_byte,
    output logic                           o_in_ready,
    input  logic                           i_q_full,
    output logic                           o_push,
    output sld_pkg::t_result               o_push_item
);

    localparam int LEFT_W = $clog2(MAX_LEN_LIMIT + 1);
    localparam logic [15:0] LEN_CEIL = 16'(MAX_LEN_LIMIT);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;

    logic [7:0]        r_sync_first;
    logic [7:0]        r_sync_second;
    logic [15:0]       r_max_len;

    logic [2:0]        r_phase,   n_phase;
    logic [23:0]       r_len,     n_len;
    logic [1:0]        r_len_idx, n_len_idx;
    logic [LEFT_W-1:0] r_left,    n_left;

    logic              accept;
    logic [15:0]       limit;
    logic [31:0]       full_len;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign limit      = (r_max_len > LEN_CEIL) ? LEN_CEIL : r_max_len;
    assign full_len   = {i_in_byte, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= sld_pkg::RST_SYNC_FIRST;
            r_sync_second <= sld_pkg::RST_SYNC_SECOND;
            r_max_len     <= sld_pkg::RST_MAX_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sld_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[7:0];
                sld_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[7:0];
                sld_pkg::CFG_MAX_LEN:     r_max_len     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_len_idx   = r_len_idx;
        n_left      = r_left;
        o_push      = 1'b0;
        o_push_item = '{result_kind: sld_pkg::KIND_BYTE, payload_byte: 8'd0,
                        last_of_message: 1'b0};
        if (accept) begin
            unique case (r_phase)
                PH_SECOND: begin
                    // second-byte match wins; a repeated first byte keeps the hunt armed
                    if (i_in_byte == r_sync_second) begin
                        n_phase   = PH_LENGTH;
                        n_len     = '0;
                        n_len_idx = '0;
                    end else if (i_in_byte != r_sync_first) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LENGTH: begin
                    unique case (r_len_idx)
                        2'd0: n_len[7:0]   = i_in_byte;
                        2'd1: n_len[15:8]  = i_in_byte;
                        2'd2: n_len[23:16] = i_in_byte;
                        default: ;
                    endcase
                    if (r_len_idx != 2'd3) begin
                        n_len_idx = r_len_idx + 2'd1;
                    end else begin
                        n_len_idx = '0;
                        if (full_len == 32'd0) begin
                            n_phase     = PH_HUNT;
                            o_push      = 1'b1;
                            o_push_item.result_kind     = sld_pkg::KIND_EMPTY;
                            o_push_item.last_of_message = 1'b1;
                        end else if (full_len > {16'd0, limit}) begin
                            n_phase = PH_HUNT;
                            o_push  = 1'b1;
                            o_push_item.result_kind = sld_pkg::KIND_ERROR;
                        end else begin
                            n_left  = full_len[LEFT_W-1:0];
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_push                   = 1'b1;
                    o_push_item.payload_byte = i_in_byte;
                    if (r_left <= LEFT_W'(1)) begin
                        n_left                      = '0;
                        n_phase                     = PH_HUNT;
                        o_push_item.last_of_message = 1'b1;
                    end else begin
                        n_left = r_left - LEFT_W'(1);
                    end
                end
                default: begin
                    n_phase = (i_in_byte == r_sync_first) ? PH_SECOND : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_len_idx <= '0;
            r_len     <= '0;
            r_left    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_len_idx <= n_len_idx;
            r_len     <= n_len;
            r_left    <= n_left;
        end
    end

endmodule

// File: hdl/sld_queue.sv
// Short result queue between the front end and the output stage.
// Depends on sld_pkg for the result type and depth.
module sld_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sld_pkg::t_result i_push_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output sld_pkg::t_result o_item
);

    sld_pkg::t_result                 r_mem [sld_pkg::QUEUE_DEPTH];
    logic [sld_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [sld_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [sld_pkg::QUEUE_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == sld_pkg::QUEUE_CNT_W'(sld_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/sld_back.sv
// Output stage: registers one result and presents it on the result channel.
// Depends on sld_pkg for the result type.
module sld_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  sld_pkg::t_result i_q_item,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output sld_pkg::t_result o_out_item
);

    logic             r_valid;
    sld_pkg::t_result r_item;

    // refill whenever the held result is empty or leaving this cycle
    assign o_pop       = i_q_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
    end

endmodule
